// ===== rtl/core/nmsf_pkg.sv =====
// ----------------------------------------------------------------------------
// Neighbour mean smoothing filter package
// Shared constants, control structs and the constant-divisor digit step used
// by the front end, the back end and the top level of the filter.
// ----------------------------------------------------------------------------
package nmsf_pkg;

  // Configuration register widths and reset values.
  localparam int FW_BITS  = 11;
  localparam int FH_BITS  = 16;
  localparam int CFG_BITS = 16;
  localparam int ROW_BITS = 16;

  localparam logic [FW_BITS-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FH_BITS-1:0] FRAME_HEIGHT_RST = 16'd480;

  // Depth of the job queue between front end and back end.
  localparam int JOB_DEPTH = 4;

  // Fraction bits of the 16.4 result.
  localparam int FRAC_BITS = 4;

  // Neighbour counts for a corner, an edge and an inner pixel.
  localparam int NBR_CORNER = 3;
  localparam int NBR_EDGE   = 5;
  localparam int NBR_INNER  = 8;

  // Long division by a constant, one byte of dividend per step.
  localparam int DIGIT_BITS    = 8;
  localparam int REM_BITS      = 3;
  localparam int PART_BITS     = DIGIT_BITS + REM_BITS;
  localparam int DIV_PROD_BITS = 22;
  // Round-up reciprocals, exact for every partial dividend below 2^PART_BITS.
  localparam int RECIP3       = 1366;
  localparam int RECIP3_SHIFT = 12;
  localparam int RECIP5       = 1639;
  localparam int RECIP5_SHIFT = 13;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // Number of in-frame neighbours of one result.
  typedef enum logic [1:0] {
    CNT_3,
    CNT_5,
    CNT_8
  } nbr_cnt_t;

  // Classification of one window position, made by the front end.
  typedef struct packed {
    logic top_cut;    // window row above the result is outside the frame
    logic left_cut;   // window column left of the result is outside the frame
    logic emit_main;  // the result one row up and one column left is complete
    logic emit_col;   // the last column of the row above is complete
    logic last_row;   // the current row is the last row of the frame
  } job_ctl_t;

  // Side-band flags of one result beat.
  typedef struct packed {
    logic row_end;
    logic frame_end;
    logic run_last;
  } res_tag_t;

  typedef struct packed {
    logic [DIGIT_BITS-1:0] quo;
    logic [REM_BITS-1:0]   rem;
  } div_digit_t;

  // One step of long division by 3, 5 or 8: divides {rem_in, digit}.
  function automatic div_digit_t div_digit(input logic [REM_BITS-1:0]   rem_in,
                                           input logic [DIGIT_BITS-1:0] digit,
                                           input nbr_cnt_t              cnt);
    logic [PART_BITS-1:0]     part;
    logic [DIV_PROD_BITS-1:0] prod;
    logic [PART_BITS-1:0]     back;
    logic [PART_BITS-1:0]     diff;
    div_digit_t               res;
    part = {rem_in, digit};
    prod = '0;
    back = '0;
    diff = '0;
    res  = '0;
    case (cnt)
      CNT_3: begin
        prod     = DIV_PROD_BITS'(part) * DIV_PROD_BITS'(RECIP3);
        res.quo  = prod[RECIP3_SHIFT +: DIGIT_BITS];
        back     = PART_BITS'(res.quo) * PART_BITS'(NBR_CORNER);
        diff     = part - back;
        res.rem  = diff[REM_BITS-1:0];
      end
      CNT_5: begin
        prod     = DIV_PROD_BITS'(part) * DIV_PROD_BITS'(RECIP5);
        res.quo  = prod[RECIP5_SHIFT +: DIGIT_BITS];
        back     = PART_BITS'(res.quo) * PART_BITS'(NBR_EDGE);
        diff     = part - back;
        res.rem  = diff[REM_BITS-1:0];
      end
      CNT_8: begin
        res.quo = part[REM_BITS +: DIGIT_BITS];
        res.rem = part[REM_BITS-1:0];
      end
      default: begin
        res = '0;
      end
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/core/nmsf_fifo.sv =====
// ----------------------------------------------------------------------------
// Neighbour mean smoothing filter queue
// Small register queue with a fill count. The writer never pushes into a
// full queue; the count lets it reserve room ahead of time.
// ----------------------------------------------------------------------------
module nmsf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           pop_data,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] data_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             pop_ok;

  // A pop only counts while something is stored.
  assign pop_ok = pop && (count_r != '0);

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    case ({push, pop_ok})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      data_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data = data_r[rd_ptr_r];
  assign empty    = (count_r == '0);
  assign count    = count_r;

endmodule

// ===== rtl/core/nmsf_front.sv =====
// ----------------------------------------------------------------------------
// Neighbour mean smoothing filter front end
// Tracks the raster position, reads and updates the two line stores, shifts
// the 3x3 window and classifies each position into a job for the back end.
// ----------------------------------------------------------------------------
module nmsf_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             accept,
  input  logic [PIXEL_BITS-1:0]            pixel,
  input  logic [$clog2(MAX_WIDTH)-1:0]     col_last_idx,
  input  logic [nmsf_pkg::ROW_BITS-1:0]    row_last_idx,
  output logic                             busy,
  output logic                             job_valid,
  output logic [8:0][PIXEL_BITS-1:0]       job_win,
  output nmsf_pkg::job_ctl_t               job_ctl
);

  localparam int CB = $clog2(MAX_WIDTH);
  localparam int RB = nmsf_pkg::ROW_BITS;

  logic [CB-1:0]             col_r, col_nxt;
  logic [RB-1:0]             row_r, row_nxt;
  logic                      col_last;
  logic                      row_last;
  nmsf_pkg::job_ctl_t        ctl_nxt, ctl_r;

  logic [PIXEL_BITS-1:0]     upper_mem  [MAX_WIDTH];
  logic [PIXEL_BITS-1:0]     middle_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0]     up_rd_r;
  logic [PIXEL_BITS-1:0]     mid_rd_r;
  logic [PIXEL_BITS-1:0]     pix_r;
  logic [CB-1:0]             idx_r;
  logic                      f2_v_r;
  logic [8:0][PIXEL_BITS-1:0] win_r;

  // Classify the current raster position and advance the counters.
  always_comb begin
    col_last          = (col_r >= col_last_idx);
    row_last          = (row_r >= row_last_idx);
    ctl_nxt.top_cut   = (row_r == RB'(1));
    ctl_nxt.left_cut  = (col_r == CB'(1));
    ctl_nxt.emit_main = (row_r != '0) && (col_r != '0);
    ctl_nxt.emit_col  = (row_r != '0) && col_last;
    ctl_nxt.last_row  = row_last;
    if (col_last) begin
      col_nxt = '0;
      row_nxt = row_last ? '0 : row_r + RB'(1);
    end else begin
      col_nxt = col_r + CB'(1);
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      f2_v_r <= 1'b0;
    end else begin
      f2_v_r <= accept;
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  // Second stage payload: the pixel, its column and its classification.
  always_ff @(posedge clk) begin
    if (accept) begin
      pix_r <= pixel;
      idx_r <= col_r;
      ctl_r <= ctl_nxt;
    end
  end

  // Line stores: read on accept, written back in the following cycle at the same column.
  always_ff @(posedge clk) begin
    if (accept) begin
      up_rd_r  <= upper_mem[col_r];
      mid_rd_r <= middle_mem[col_r];
    end
    if (f2_v_r) begin
      upper_mem[idx_r]  <= mid_rd_r;
      middle_mem[idx_r] <= pix_r;
    end
  end

  // The window after the shift; it is both the job and the next window.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      job_win[k*3]     = win_r[k*3 + 1];
      job_win[k*3 + 1] = win_r[k*3 + 2];
    end
    job_win[2] = up_rd_r;
    job_win[5] = mid_rd_r;
    job_win[8] = pix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (f2_v_r) begin
      win_r <= job_win;
    end
  end

  assign busy      = f2_v_r;
  assign job_valid = f2_v_r && (ctl_r.emit_main || ctl_r.emit_col);
  assign job_ctl   = ctl_r;

endmodule

// ===== rtl/core/nmsf_back.sv =====
// ----------------------------------------------------------------------------
// Neighbour mean smoothing filter back end
// Expands each job into its results, sums the in-frame neighbours and divides
// by the neighbour count in a byte-per-stage long division pipeline.
// ----------------------------------------------------------------------------
module nmsf_back #(
  parameter int PIXEL_BITS = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     job_valid,
  input  logic [8:0][PIXEL_BITS-1:0]               job_win,
  input  nmsf_pkg::job_ctl_t                       job_ctl,
  output logic                                     job_pop,
  input  logic                                     res_ok,
  output logic                                     res_valid,
  output logic [PIXEL_BITS+nmsf_pkg::FRAC_BITS-1:0] res_value,
  output nmsf_pkg::res_tag_t                       res_tag,
  output logic [$clog2((PIXEL_BITS+14)/8+2)-1:0]   inflight
);

  localparam int DB         = nmsf_pkg::DIGIT_BITS;
  localparam int SUMW       = PIXEL_BITS + 3;
  localparam int XW         = SUMW + nmsf_pkg::FRAC_BITS;
  localparam int DIV_STAGES = (XW + DB - 1) / DB;
  localparam int XP         = DIV_STAGES * DB;
  localparam int IFW        = $clog2(DIV_STAGES + 2);
  localparam int OW         = PIXEL_BITS + nmsf_pkg::FRAC_BITS;

  logic [3:0]             slots;
  logic [3:0]             done_r;
  logic [3:0]             pend;
  logic [3:0]             pick;
  logic                   last_slot;
  logic                   issue;
  logic [1:0]             kc, mc;
  logic                   klo, mlo;
  logic [SUMW-1:0]        sum;
  nmsf_pkg::nbr_cnt_t     cnt;
  nmsf_pkg::res_tag_t     tag;

  logic [DIV_STAGES:0]    v_r;
  nmsf_pkg::res_tag_t     tag_r [DIV_STAGES+1];
  logic [XP-1:0]          q_r   [DIV_STAGES+1];
  logic [XP-1:0]          x_r   [DIV_STAGES];
  logic [nmsf_pkg::REM_BITS-1:0] rem_r [DIV_STAGES];
  nmsf_pkg::nbr_cnt_t     cnt_r [DIV_STAGES];
  nmsf_pkg::div_digit_t   dig   [DIV_STAGES];
  logic [XP-1:0]          q_nxt [DIV_STAGES];

  // Results of a job in output order: main, main of the last row,
  // row end, row end of the last row.
  always_comb begin
    slots     = {job_ctl.emit_col && job_ctl.last_row, job_ctl.emit_col,
                 job_ctl.emit_main && job_ctl.last_row, job_ctl.emit_main};
    pend      = slots & ~done_r;
    pick      = pend & (~pend + 4'd1);
    last_slot = ((pend & ~pick) == 4'd0);
    issue     = job_valid && res_ok;
    job_pop   = issue && last_slot;
  end

  // Centre and cut-off edges of the picked result.
  always_comb begin
    kc            = 2'd1;
    mc            = 2'd1;
    klo           = job_ctl.top_cut;
    mlo           = job_ctl.left_cut;
    tag.row_end   = 1'b0;
    tag.frame_end = 1'b0;
    tag.run_last  = last_slot;
    case (pick)
      4'b0001: begin
        kc = 2'd1;
        mc = 2'd1;
      end
      4'b0010: begin
        kc  = 2'd2;
        klo = 1'b1;
      end
      4'b0100: begin
        mc          = 2'd2;
        mlo         = 1'b1;
        tag.row_end = 1'b1;
      end
      4'b1000: begin
        kc            = 2'd2;
        mc            = 2'd2;
        klo           = 1'b1;
        mlo           = 1'b1;
        tag.row_end   = 1'b1;
        tag.frame_end = 1'b1;
      end
      default: begin
        kc = 2'd1;
        mc = 2'd1;
      end
    endcase
  end

  // Sum of the in-frame neighbours and their count.
  always_comb begin
    sum = '0;
    for (int k = 0; k < 3; k++) begin
      for (int m = 0; m < 3; m++) begin
        if ((k >= int'(klo)) && (m >= int'(mlo)) && !((k == int'(kc)) && (m == int'(mc)))) begin
          sum = sum + SUMW'(job_win[k*3 + m]);
        end
      end
    end
    if (klo && mlo) begin
      cnt = nmsf_pkg::CNT_3;
    end else if (klo || mlo) begin
      cnt = nmsf_pkg::CNT_5;
    end else begin
      cnt = nmsf_pkg::CNT_8;
    end
  end

  // Slot bookkeeping for the job at the head of the queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= '0;
    end else if (issue) begin
      done_r <= last_slot ? 4'd0 : (done_r | pick);
    end
  end

  // One division digit per stage, most significant byte first.
  always_comb begin
    for (int j = 0; j < DIV_STAGES; j++) begin
      dig[j]   = nmsf_pkg::div_digit(rem_r[j], x_r[j][XP-1-DB*j -: DB], cnt_r[j]);
      q_nxt[j] = q_r[j];
      q_nxt[j][XP-1-DB*j -: DB] = dig[j].quo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[DIV_STAGES-1:0], issue};
    end
  end

  always_ff @(posedge clk) begin
    x_r[0]   <= XP'({sum, {nmsf_pkg::FRAC_BITS{1'b0}}});
    rem_r[0] <= '0;
    cnt_r[0] <= cnt;
    q_r[0]   <= '0;
    tag_r[0] <= tag;
    for (int j = 0; j < DIV_STAGES; j++) begin
      q_r[j+1]   <= q_nxt[j];
      tag_r[j+1] <= tag_r[j];
    end
    for (int j = 1; j < DIV_STAGES; j++) begin
      x_r[j]   <= x_r[j-1];
      rem_r[j] <= dig[j-1].rem;
      cnt_r[j] <= cnt_r[j-1];
    end
  end

  assign res_valid = v_r[DIV_STAGES];
  assign res_value = q_r[DIV_STAGES][OW-1:0];
  assign res_tag   = tag_r[DIV_STAGES];
  assign inflight  = IFW'($countones(v_r));

endmodule

// ===== rtl/core/neighbour_mean_smoothing_filter.sv =====
// ----------------------------------------------------------------------------
// Neighbour mean smoothing filter
// 3x3 mean of the in-frame neighbours of every pixel, centre excluded.
// ----------------------------------------------------------------------------
// The filter takes one pixel per clock while in_full is low, in raster order,
// and, for every pixel, returns the mean of its in-frame neighbours (3 at a
// corner, 5 on an edge, 8 inside) as unsigned 16.4 fixed point truncated
// toward zero. Results come out one row late; the last pixel of every row but
// the first releases two results and, in the last row, every pixel after the
// first releases the results of the last two rows interleaved by column, so
// the final pixel releases four. The back end produces one result per cycle
// while the result queue has room, which sets the rate; a four-entry job
// queue absorbs the row-end bursts. An accepted pixel passes the front end's
// pixel register and the job queue; its results then pass the DIV_STAGES,
// (PIXEL_BITS + 14) / 8, long division stages into the result queue. The
// line stores are not cleared after reset and need no clearing pass; the
// frame width must not grow in the middle of a frame.
module neighbour_mean_smoothing_filter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  // Configuration write port.
  input  logic                                     cfg_we,
  input  logic [0:0]                               cfg_index,
  input  logic [nmsf_pkg::CFG_BITS-1:0]            cfg_data,
  // Pixel input queue side.
  input  logic                                     in_push,
  output logic                                     in_full,
  input  logic [PIXEL_BITS-1:0]                    in_pixel_value,
  // Result queue side.
  output logic                                     out_empty,
  input  logic                                     out_pop,
  output logic [PIXEL_BITS+nmsf_pkg::FRAC_BITS-1:0] out_smoothed_value,
  output logic                                     out_row_end,
  output logic                                     out_frame_end,
  output logic                                     out_run_last
);

  localparam int CB         = $clog2(MAX_WIDTH);
  localparam int FWB        = nmsf_pkg::FW_BITS;
  localparam int FHB        = nmsf_pkg::FH_BITS;
  localparam int WB         = ($clog2(MAX_WIDTH + 1) > FWB) ? $clog2(MAX_WIDTH + 1) : FWB;
  localparam int OW         = PIXEL_BITS + nmsf_pkg::FRAC_BITS;
  localparam int DIV_STAGES = (PIXEL_BITS + 14) / 8;
  localparam int PIPE_LAT   = DIV_STAGES + 1;
  localparam int IFW        = $clog2(PIPE_LAT + 1);
  localparam int OUT_DEPTH  = PIPE_LAT + 2;
  localparam int OCW        = $clog2(OUT_DEPTH + 1);
  localparam int RSW        = ((OCW > IFW) ? OCW : IFW) + 1;
  localparam int JD         = nmsf_pkg::JOB_DEPTH;
  localparam int JCW        = $clog2(JD + 1);
  localparam int JW         = 9 * PIXEL_BITS + $bits(nmsf_pkg::job_ctl_t);
  localparam int RW         = OW + $bits(nmsf_pkg::res_tag_t);

  logic [FWB-1:0]              frame_width_r;
  logic [FHB-1:0]              frame_height_r;
  logic [WB-1:0]               fw_ext;
  logic [WB-1:0]               w_last_ext;
  logic [CB-1:0]               col_last_idx;
  logic [FHB-1:0]              row_last_idx;

  logic                        accept;
  logic                        front_busy;
  logic                        job_valid;
  logic [8:0][PIXEL_BITS-1:0]  job_win;
  nmsf_pkg::job_ctl_t          job_ctl;

  logic [JW-1:0]               jq_in, jq_out;
  logic                        jq_empty;
  logic [JCW-1:0]              jq_count;
  logic [8:0][PIXEL_BITS-1:0]  head_win;
  nmsf_pkg::job_ctl_t          head_ctl;
  logic                        job_pop;

  logic                        res_ok;
  logic                        res_valid;
  logic [OW-1:0]               res_value;
  nmsf_pkg::res_tag_t          res_tag;
  logic [IFW-1:0]              inflight;
  logic [RW-1:0]               rq_in, rq_out;
  logic [OCW-1:0]              rq_count;
  nmsf_pkg::res_tag_t          out_tag;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= nmsf_pkg::FRAME_WIDTH_RST;
      frame_height_r <= nmsf_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      case (nmsf_pkg::cfg_reg_t'(cfg_index))
        nmsf_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[FWB-1:0];
        nmsf_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_data[FHB-1:0];
        default: begin
        end
      endcase
    end
  end

  // Last column and last row index, with the width and height clamped.
  always_comb begin
    fw_ext = WB'(frame_width_r);
    if (fw_ext < WB'(2)) begin
      w_last_ext = WB'(1);
    end else if (fw_ext > WB'(MAX_WIDTH)) begin
      w_last_ext = WB'(MAX_WIDTH - 1);
    end else begin
      w_last_ext = fw_ext - WB'(1);
    end
    col_last_idx = w_last_ext[CB-1:0];
    row_last_idx = (frame_height_r < FHB'(2)) ? FHB'(1) : frame_height_r - FHB'(1);
  end

  // A beat is taken only when the job queue has room for it and the one
  // still in the front end.
  assign in_full = ((JCW+1)'(jq_count) + (JCW+1)'(front_busy)) >= (JCW+1)'(JD);
  assign accept  = in_push && !in_full;

  nmsf_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .pixel        (in_pixel_value),
    .col_last_idx (col_last_idx),
    .row_last_idx (row_last_idx),
    .busy         (front_busy),
    .job_valid    (job_valid),
    .job_win      (job_win),
    .job_ctl      (job_ctl)
  );

  // Job queue between front end and back end.
  assign jq_in = {job_win, job_ctl};

  nmsf_fifo #(
    .WIDTH (JW),
    .DEPTH (JD)
  ) u_job_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_valid),
    .push_data (jq_in),
    .pop       (job_pop),
    .pop_data  (jq_out),
    .empty     (jq_empty),
    .count     (jq_count)
  );

  assign {head_win, head_ctl} = jq_out;

  // A result is started only when the result queue has a slot for it.
  assign res_ok = ((RSW)'(rq_count) + (RSW)'(inflight)) < (RSW)'(OUT_DEPTH);

  nmsf_back #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (!jq_empty),
    .job_win   (head_win),
    .job_ctl   (head_ctl),
    .job_pop   (job_pop),
    .res_ok    (res_ok),
    .res_valid (res_valid),
    .res_value (res_value),
    .res_tag   (res_tag),
    .inflight  (inflight)
  );

  // Result queue toward the consumer.
  assign rq_in = {res_value, res_tag};

  nmsf_fifo #(
    .WIDTH (RW),
    .DEPTH (OUT_DEPTH)
  ) u_res_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (rq_in),
    .pop       (out_pop),
    .pop_data  (rq_out),
    .empty     (out_empty),
    .count     (rq_count)
  );

  assign {out_smoothed_value, out_tag} = rq_out;
  assign out_row_end   = out_tag.row_end;
  assign out_frame_end = out_tag.frame_end;
  assign out_run_last  = out_tag.run_last;

endmodule

// ===== dv/tb_neighbour_mean_smoothing_filter.sv =====
// ----------------------------------------------------------------------------
// Neighbour mean smoothing filter testbench
// Streams frames of pixels into the filter under random idling on both sides.
// Every result beat is checked against an in-bench model of the line stores,
// the 3x3 window and the neighbour mean. The run covers small and clamped
// frame sizes, mid-frame register changes and a long result-side stall.
// ----------------------------------------------------------------------------
module tb_neighbour_mean_smoothing_filter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIX_BITS      = 16;
  localparam int OUT_BITS      = PIX_BITS + nmsf_pkg::FRAC_BITS;
  localparam int FWB           = nmsf_pkg::FW_BITS;
  localparam int FHB           = nmsf_pkg::FH_BITS;
  localparam int CFGW          = nmsf_pkg::CFG_BITS;
  localparam int LINE_DEPTH    = 1024;
  localparam int IDLE_PCT      = 11;
  localparam int HOLD_CYCLES   = 200;
  localparam int SETTLE_CYCLES = 20;
  localparam int CLAMP_PIXELS  = 24;
  localparam int RANDOM_PIXELS = 130;
  localparam int CYCLE_LIMIT   = 200000;

  typedef enum {PIX_ZERO, PIX_FULL, PIX_RANDOM, PIX_MIXED} pix_mode_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] value;
    logic                row_end;
    logic                frame_end;
    logic                run_last;
  } smooth_res_t;

  // DUT connections, all inputs known from time zero.
  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                cfg_we         = 1'b0;
  logic [0:0]          cfg_index      = '0;
  logic [CFGW-1:0]     cfg_data       = '0;
  logic                in_push        = 1'b0;
  logic                in_full;
  logic [PIX_BITS-1:0] in_pixel_value = '0;
  logic                out_empty;
  logic                out_pop        = 1'b0;
  logic [OUT_BITS-1:0] out_smoothed_value;
  logic                out_row_end;
  logic                out_frame_end;
  logic                out_run_last;

  // Filter model state.
  logic [PIX_BITS-1:0] upper_store [LINE_DEPTH];
  logic [PIX_BITS-1:0] middle_store [LINE_DEPTH];
  logic [PIX_BITS-1:0] win [3][3];
  int unsigned         col_pos;
  int unsigned         row_pos;
  logic [FWB-1:0]      width_reg;
  logic [FHB-1:0]      height_reg;

  // Pixels waiting to be offered and result beats waiting to arrive.
  logic [PIX_BITS-1:0] pixel_backlog [$];
  smooth_res_t         pending_results [$];

  // Run bookkeeping.
  int          errors        = 0;
  int unsigned pixels_in     = 0;
  int unsigned results_out   = 0;
  int unsigned frames_done   = 0;
  int unsigned full_cycles   = 0;
  int unsigned cycle_count   = 0;
  bit          steady        = 1'b0;
  int unsigned hold_requests = 0;
  int unsigned holds_served  = 0;
  int unsigned hold_left     = 0;

  neighbour_mean_smoothing_filter #(
    .MAX_WIDTH (LINE_DEPTH),
    .PIXEL_BITS(PIX_BITS)
  ) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_pixel_value    (in_pixel_value),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_smoothed_value(out_smoothed_value),
    .out_row_end       (out_row_end),
    .out_frame_end     (out_frame_end),
    .out_run_last      (out_run_last)
  );

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Frame width as the filter uses it, clamped to the line store.
  function automatic int unsigned eff_width();
    if (width_reg < 2) return 2;
    if (width_reg > LINE_DEPTH) return LINE_DEPTH;
    return int'(width_reg);
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg < 2) return 2;
    return int'(height_reg);
  endfunction

  // Mean of window rows klo..2 and columns mlo..2, leaving out cell (kc, mc).
  function automatic logic [OUT_BITS-1:0] window_mean(int kc, int klo, int mc, int mlo);
    longint unsigned sum;
    longint unsigned cnt;
    int              k;
    int              m;
    sum = 0;
    cnt = 0;
    for (k = klo; k <= 2; k++) begin
      for (m = mlo; m <= 2; m++) begin
        if (!(k == kc && m == mc)) begin
          sum += win[k][m];
          cnt++;
        end
      end
    end
    if (cnt == 0) return '0;
    return OUT_BITS'((sum << nmsf_pkg::FRAC_BITS) / cnt);
  endfunction

  function automatic smooth_res_t make_res(logic [OUT_BITS-1:0] v, logic re, logic fe);
    smooth_res_t res;
    res.value     = v;
    res.row_end   = re;
    res.frame_end = fe;
    res.run_last  = 1'b0;
    return res;
  endfunction

  // Pixels still needed to close the current frame at the current settings.
  function automatic int unsigned pixels_to_frame_end();
    int unsigned w;
    int unsigned h;
    int unsigned row_left;
    w = eff_width();
    h = eff_height();
    row_left = (col_pos >= w - 1) ? 1 : w - col_pos;
    if (row_pos >= h - 1) return row_left;
    return row_left + (h - 1 - row_pos) * w;
  endfunction

  // Advance the filter model by one pixel and queue the beats it releases.
  task automatic advance_filter(input logic [PIX_BITS-1:0] pix);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    int unsigned idx;
    int          klo;
    int          mlo;
    int          k;
    bit          row_last;
    bit          col_last;
    smooth_res_t burst [$];
    w = eff_width();
    h = eff_height();
    c = col_pos;
    r = row_pos;
    idx = (c < LINE_DEPTH) ? c : LINE_DEPTH - 1;

    // Shift the window left and load the new column from the line stores.
    for (k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = upper_store[idx];
    win[1][2] = middle_store[idx];
    win[2][2] = pix;
    upper_store[idx]  = middle_store[idx];
    middle_store[idx] = pix;

    row_last = (r >= h - 1);
    col_last = (c >= w - 1);
    klo = (r == 1) ? 1 : 0;
    mlo = (c == 1) ? 1 : 0;

    // In the last row each release of the row above is followed by its twin.
    if (r >= 1 && c >= 1) begin
      burst.push_back(make_res(window_mean(1, klo, 1, mlo), 1'b0, 1'b0));
      if (row_last) burst.push_back(make_res(window_mean(2, 1, 1, mlo), 1'b0, 1'b0));
    end
    if (r >= 1 && col_last) begin
      burst.push_back(make_res(window_mean(1, klo, 2, 1), 1'b1, 1'b0));
      if (row_last) burst.push_back(make_res(window_mean(2, 1, 2, 1), 1'b1, 1'b1));
    end
    if (burst.size() != 0) burst[burst.size()-1].run_last = 1'b1;
    foreach (burst[i]) pending_results.push_back(burst[i]);

    if (col_last) begin
      col_pos = 0;
      row_pos = row_last ? 0 : ((r + 1) & 32'hFFFF);
    end else begin
      col_pos = c + 1;
    end
  endtask

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endfunction

  // Register write; the model takes the value at the edge that writes it.
  task automatic write_reg(input nmsf_pkg::cfg_reg_t idx, input logic [CFGW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == nmsf_pkg::REG_FRAME_WIDTH) begin
      width_reg = val[FWB-1:0];
    end else begin
      height_reg = val[FHB-1:0];
    end
  endtask

  task automatic send_pixels(input int unsigned count, input pix_mode_t mode);
    logic [PIX_BITS-1:0] px;
    repeat (count) begin
      case (mode)
        PIX_ZERO: px = '0;
        PIX_FULL: px = '1;
        PIX_MIXED: begin
          case ($urandom_range(0, 2))
            0:       px = '0;
            1:       px = '1;
            default: px = PIX_BITS'($urandom);
          endcase
        end
        default: px = PIX_BITS'($urandom);
      endcase
      pixel_backlog.push_back(px);
    end
  endtask

  // Wait until every pixel is in and every beat is out, then let the pipe settle.
  task automatic wait_idle();
    while (pixel_backlog.size() != 0 || in_push || pending_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Input driver: offers backlog pixels and runs the model on each accepted beat.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && in_full) full_cycles++;
      if (in_push && !in_full) begin
        advance_filter(in_pixel_value);
        pixels_in++;
      end
      if (!in_push || !in_full) begin
        if (pixel_backlog.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_push        <= 1'b1;
          in_pixel_value <= pixel_backlog.pop_front();
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each popped beat and paces pop, with long holds on request.
  always @(posedge clk) begin
    smooth_res_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        results_out++;
        if (out_frame_end) frames_done++;
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected, actual value %0d",
                   $time, out_smoothed_value);
        end else begin
          want = pending_results.pop_front();
          check_field("smoothed_value", want.value, out_smoothed_value);
          check_field("row_end", want.row_end, out_row_end);
          check_field("frame_end", want.frame_end, out_frame_end);
          check_field("run_last", want.run_last, out_run_last);
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
        out_pop <= 1'b0;
      end else begin
        out_pop <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout with %0d result beats still expected", $time,
             pending_results.size());
    $display("FAIL neighbour_mean_smoothing_filter");
    $finish;
  end

  // Stimulus sequence.
  initial begin
    int unsigned    random_px;
    int unsigned    total;
    int unsigned    split;
    logic [FWB-1:0] wsel;
    logic [FHB-1:0] hsel;
    pix_mode_t      mode;
    random_px = 0;

    // Model state after reset.
    foreach (upper_store[i]) begin
      upper_store[i]  = '0;
      middle_store[i] = '0;
    end
    foreach (win[k, m]) win[k][m] = '0;
    col_pos    = 0;
    row_pos    = 0;
    width_reg  = nmsf_pkg::FRAME_WIDTH_RST;
    height_reg = nmsf_pkg::FRAME_HEIGHT_RST;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Smallest frame: every pixel is a corner and the final pixel releases four beats.
    write_reg(nmsf_pkg::REG_FRAME_WIDTH, CFGW'(2));
    write_reg(nmsf_pkg::REG_FRAME_HEIGHT, CFGW'(2));
    pixel_backlog.push_back(16'h0000);
    pixel_backlog.push_back(16'hFFFF);
    pixel_backlog.push_back(16'hFFFF);
    pixel_backlog.push_back(16'h0000);
    wait_idle();

    // Full-scale pixels give the largest sums for corners, edges and the inner pixel.
    write_reg(nmsf_pkg::REG_FRAME_WIDTH, CFGW'(3));
    write_reg(nmsf_pkg::REG_FRAME_HEIGHT, CFGW'(3));
    send_pixels(9, PIX_FULL);
    wait_idle();

    // Width and height below the minimum act as two.
    write_reg(nmsf_pkg::REG_FRAME_WIDTH, CFGW'(1));
    write_reg(nmsf_pkg::REG_FRAME_HEIGHT, CFGW'(0));
    send_pixels(4, PIX_MIXED);
    wait_idle();

    // Tallest height, then shrink it mid-frame so the current row becomes the last.
    write_reg(nmsf_pkg::REG_FRAME_WIDTH, CFGW'(2));
    write_reg(nmsf_pkg::REG_FRAME_HEIGHT, 16'hFFFF);
    send_pixels(4, PIX_RANDOM);
    wait_idle();
    write_reg(nmsf_pkg::REG_FRAME_HEIGHT, CFGW'(2));
    send_pixels(pixels_to_frame_end(), PIX_RANDOM);
    wait_idle();

    // Width above the line store clamps to its depth, so a short first row
    // does not end; the width then shrinks and the cut row closes.
    write_reg(nmsf_pkg::REG_FRAME_WIDTH, 16'hFFFF);
    write_reg(nmsf_pkg::REG_FRAME_HEIGHT, CFGW'(2));
    send_pixels(CLAMP_PIXELS, PIX_RANDOM);
    wait_idle();
    write_reg(nmsf_pkg::REG_FRAME_WIDTH, CFGW'($urandom_range(2, 6)));
    send_pixels(pixels_to_frame_end(), PIX_MIXED);
    wait_idle();

    // The result side holds off while pixels keep coming, so the input backs up.
    write_reg(nmsf_pkg::REG_FRAME_WIDTH, CFGW'(8));
    write_reg(nmsf_pkg::REG_FRAME_HEIGHT, CFGW'(6));
    hold_requests++;
    send_pixels(48, PIX_RANDOM);
    wait_idle();

    // A frame with no idling on either side.
    steady = 1'b1;
    write_reg(nmsf_pkg::REG_FRAME_WIDTH, CFGW'(6));
    write_reg(nmsf_pkg::REG_FRAME_HEIGHT, CFGW'(6));
    send_pixels(36, PIX_RANDOM);
    wait_idle();
    steady = 1'b0;

    // Random frames; some change their settings part way through.
    while (random_px < RANDOM_PIXELS) begin
      case ($urandom_range(0, 9))
        0:       wsel = FWB'($urandom_range(0, 1));
        1:       wsel = FWB'($urandom_range(9, 24));
        default: wsel = FWB'($urandom_range(2, 8));
      endcase
      case ($urandom_range(0, 9))
        0:       hsel = FHB'($urandom_range(0, 1));
        1:       hsel = FHB'($urandom_range(7, 10));
        default: hsel = FHB'($urandom_range(2, 6));
      endcase
      case ($urandom_range(0, 7))
        0:       mode = PIX_ZERO;
        1:       mode = PIX_FULL;
        2, 3:    mode = PIX_MIXED;
        default: mode = PIX_RANDOM;
      endcase
      // Upper data bits of a width write are not part of the register.
      write_reg(nmsf_pkg::REG_FRAME_WIDTH, {5'($urandom), wsel});
      if ($urandom_range(0, 3) != 0) write_reg(nmsf_pkg::REG_FRAME_HEIGHT, hsel);
      total = pixels_to_frame_end();
      if (total > 1 && $urandom_range(0, 2) == 0) begin
        // Mid-frame change: the width may only shrink, the height may move freely.
        split = $urandom_range(1, total - 1);
        send_pixels(split, mode);
        random_px += split;
        wait_idle();
        write_reg(nmsf_pkg::REG_FRAME_WIDTH, CFGW'($urandom_range(0, eff_width())));
        write_reg(nmsf_pkg::REG_FRAME_HEIGHT, CFGW'($urandom_range(0, 8)));
      end
      total = pixels_to_frame_end();
      send_pixels(total, mode);
      random_px += total;
      wait_idle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Streamed %0d pixels and checked %0d result beats over %0d frames.",
             pixels_in, results_out, frames_done);
    $display("Input backed up for %0d cycles; clamped widths and heights up to 65535 set.",
             full_cycles);
    if (errors == 0) begin
      $display("PASS neighbour_mean_smoothing_filter");
    end else begin
      $display("FAIL neighbour_mean_smoothing_filter");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/nmsf_pkg.sv
rtl/core/nmsf_fifo.sv
rtl/core/nmsf_front.sv
rtl/core/nmsf_back.sv
rtl/core/neighbour_mean_smoothing_filter.sv
dv/tb_neighbour_mean_smoothing_filter.sv
